// ===== src/bba_pkg.sv =====
// bba_pkg: shared types, constants and a helper function of the bitmap block allocator
// no dependencies
package bba_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned IDX_BITS = 9;
	localparam int unsigned BLK_BITS = 14;
	localparam int unsigned POS_BITS = 5;
	localparam int unsigned USE_BITS = 10;
	localparam logic [WORD_BITS-1:0] WORD_FULL = 32'hFFFF_FFFF;
	localparam logic [WORD_BITS-1:0] WORD_TOP = 32'h8000_0000;
	localparam logic [USE_BITS-1:0] USE_RESET = 10'd512;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_ALLOC = 1'b1
	} kind_t;

	// position of the first clear bit counted from the msb
	function automatic logic [POS_BITS-1:0] first_clear(input word_t w);
		logic [POS_BITS-1:0] pos;
		pos = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!w[i]) begin
				pos = POS_BITS'(WORD_BITS - 1 - i);
			end
		end
		return pos;
	endfunction

endpackage

// ===== src/bba_ram.sv =====
// bba_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies
module bba_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 512,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/bitmap_block_allocator.sv =====
// bitmap_block_allocator: first-fit block allocator over a free-block bitmap held in one ram
// depends on bba_pkg and bba_ram
// load, and allocate when n is zero: the result is registered at the accepting edge; otherwise
// allocate answers when the scan meets the first non-full word or checks the last of n words,
// where n is words_in_use capped at MAP_WORDS; the scan reads one bitmap word per cycle
// after reset a clearing pass zeroes all MAP_WORDS bitmap words with busy high
// results are one-cycle strobes on done; the receiver cannot stall
module bitmap_block_allocator #(
	parameter int unsigned MAP_WORDS = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [bba_pkg::IDX_BITS-1:0]  word_index,
	input  logic [bba_pkg::WORD_BITS-1:0] word_value,
	input  logic                          cfg_we,
	input  logic [bba_pkg::USE_BITS-1:0]  cfg_wdata,
	output logic                          done,
	output logic                          found,
	output logic [bba_pkg::IDX_BITS-1:0]  found_word,
	output logic [bba_pkg::BLK_BITS-1:0]  block_number
);

	import bba_pkg::*;

	localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned CW = $clog2(MAP_WORDS + 1);
	localparam int unsigned LW = (CW > USE_BITS) ? CW : USE_BITS;
	localparam logic [LW-1:0] MAP_LIMIT = LW'(MAP_WORDS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t            state_q;
	logic [USE_BITS-1:0] use_q;
	logic [AW-1:0]     clr_idx_q;
	logic [LW-1:0]     rd_idx_q;
	logic [LW-1:0]     chk_idx_s1;
	logic              chk_valid_s1;
	logic              done_q;
	logic              found_q;
	logic [IDX_BITS-1:0] found_word_q;
	logic [BLK_BITS-1:0] block_q;

	logic [LW-1:0]     use_ext;
	logic [LW-1:0]     limit;
	logic [LW-1:0]     load_idx;
	logic              load_ok;
	logic              accept;
	word_t             rdata;
	logic [POS_BITS-1:0] pos;
	logic              hit;
	logic              last;
	logic              issue;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	word_t             ram_wdata;

	assign use_ext = LW'(use_q);
	assign limit = (use_ext > MAP_LIMIT) ? MAP_LIMIT : use_ext;
	assign load_idx = LW'(word_index);
	assign load_ok = load_idx < MAP_LIMIT;
	assign accept = start && (state_q == ST_IDLE);
	assign pos = first_clear(rdata);
	assign hit = chk_valid_s1 && (rdata != WORD_FULL);
	assign last = chk_valid_s1 && (chk_idx_s1 == limit - LW'(1));
	assign issue = (state_q == ST_SCAN) && !hit && !last && (rd_idx_q < limit);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = clr_idx_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				ram_we = accept && (kind == KIND_LOAD) && load_ok;
				ram_waddr = load_idx[AW-1:0];
				ram_wdata = word_value;
			end
			ST_SCAN: begin
				ram_we = hit;
				ram_waddr = chk_idx_s1[AW-1:0];
				ram_wdata = rdata | (WORD_TOP >> pos);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_q <= USE_RESET;
		end else if (cfg_we) begin
			use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_idx_q <= '0;
			rd_idx_q <= '0;
			chk_idx_s1 <= '0;
			chk_valid_s1 <= 1'b0;
			done_q <= 1'b0;
			found_q <= 1'b0;
			found_word_q <= '0;
			block_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					if (clr_idx_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					rd_idx_q <= '0;
					chk_valid_s1 <= 1'b0;
					if (accept) begin
						if (kind == KIND_LOAD) begin
							done_q <= 1'b1;
							found_q <= load_ok;
							found_word_q <= word_index;
							block_q <= '0;
						end else if (limit == '0) begin
							done_q <= 1'b1;
							found_q <= 1'b0;
							found_word_q <= '0;
							block_q <= '0;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						done_q <= 1'b1;
						found_q <= 1'b1;
						found_word_q <= chk_idx_s1[IDX_BITS-1:0];
						block_q <= {chk_idx_s1[IDX_BITS-1:0], pos};
						state_q <= ST_IDLE;
					end else if (last) begin
						done_q <= 1'b1;
						found_q <= 1'b0;
						found_word_q <= '0;
						block_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						chk_valid_s1 <= issue;
						chk_idx_s1 <= rd_idx_q;
						if (issue) begin
							rd_idx_q <= rd_idx_q + LW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign found = found_q;
	assign found_word = found_word_q;
	assign block_number = block_q;

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result strobe without a transaction in flight");

	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_LOAD) |=> done)
		else $error("load transaction did not return its result in one cycle");

	a_full_zero_block: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (block_number == '0))
		else $error("unsuccessful result carries a block number");

	a_no_scan_past_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && chk_valid_s1) |-> (chk_idx_s1 < limit))
		else $error("scan checked a word beyond the search limit");

endmodule

// ===== verif/bba_grant_checker.sv =====
// bba_grant_checker: watches the request, result and config ports of the allocator
// keeps its own bitmap and search length, predicts every result and compares in order
// depends on bba_pkg
module bba_grant_checker #(
	parameter int unsigned MAP_WORDS = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          kind,
	input  logic [bba_pkg::IDX_BITS-1:0]  word_index,
	input  logic [bba_pkg::WORD_BITS-1:0] word_value,
	input  logic                          cfg_we,
	input  logic [bba_pkg::USE_BITS-1:0]  cfg_wdata,
	input  logic                          done,
	input  logic                          found,
	input  logic [bba_pkg::IDX_BITS-1:0]  found_word,
	input  logic [bba_pkg::BLK_BITS-1:0]  block_number,
	input  logic                          end_run,
	output int                            fails
);
	import bba_pkg::*;

	typedef struct packed {
		logic                found;
		logic [IDX_BITS-1:0] word;
		logic [BLK_BITS-1:0] blk;
	} grant_t;

	word_t               bitmap [MAP_WORDS];
	logic [USE_BITS-1:0] search_len;
	grant_t              grants_due [$];

	initial fails = 0;

	task automatic flag(input string what);
		$display("%0t mismatch: %s", $time, what);
		fails++;
	endtask

	function automatic grant_t predict_grant(input logic k, input logic [IDX_BITS-1:0] idx,
		input word_t val);
		grant_t g;
		int     span;
		int     pos;
		bit     hit;
		g = '0;
		hit = 1'b0;
		if (k == KIND_LOAD) begin
			if (idx < MAP_WORDS) begin
				bitmap[idx] = val;
				g.found = 1'b1;
			end
			g.word = idx;
			return g;
		end
		span = (search_len > MAP_WORDS) ? MAP_WORDS : search_len;
		for (int i = 0; i < span; i++) begin
			if (!hit && bitmap[i] != WORD_FULL) begin
				pos = 0;
				while (pos < WORD_BITS - 1 && bitmap[i][WORD_BITS-1-pos]) begin
					pos++;
				end
				bitmap[i][WORD_BITS-1-pos] = 1'b1;
				g.found = 1'b1;
				g.word = IDX_BITS'(i);
				g.blk = BLK_BITS'(i * WORD_BITS + pos);
				hit = 1'b1;
			end
		end
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			foreach (bitmap[i]) bitmap[i] = '0;
			search_len = USE_RESET;
			grants_due.delete();
		end else begin
			if (cfg_we) begin
				search_len = cfg_wdata;
			end
			if (done) begin
				if (grants_due.size() == 0) begin
					flag($sformatf("unexpected transaction: found %b word %0d block %0d",
						found, found_word, block_number));
				end else begin
					want = grants_due.pop_front();
					if (found !== want.found)
						flag($sformatf("found %b, want %b", found, want.found));
					if (found_word !== want.word)
						flag($sformatf("found_word %0d, want %0d", found_word, want.word));
					if (block_number !== want.blk)
						flag($sformatf("block_number %0d, want %0d", block_number, want.blk));
				end
			end
			if (start && !busy) begin
				grants_due.push_back(predict_grant(kind, word_index, word_value));
			end
			if (end_run && grants_due.size() != 0) begin
				flag($sformatf("%0d transactions never answered", grants_due.size()));
				grants_due.delete();
			end
		end
	end

endmodule

// ===== verif/bitmap_block_allocator_tb.sv =====
// bitmap_block_allocator_tb: drives load and allocate requests and search length writes
// depends on bba_pkg, bitmap_block_allocator and bba_grant_checker
module bitmap_block_allocator_tb;
	import bba_pkg::*;

	localparam int unsigned MAP_WORDS = 512;
	localparam int RANDOM_ITEMS = 550;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	kind_t               kind;
	logic [IDX_BITS-1:0] word_index;
	word_t               word_value;
	logic                cfg_we;
	logic [USE_BITS-1:0] cfg_wdata;
	logic                done;
	logic                found;
	logic [IDX_BITS-1:0] found_word;
	logic [BLK_BITS-1:0] block_number;
	logic                end_run;
	int                  fails;
	int                  n_issued = 0;
	int                  n_answered = 0;

	bitmap_block_allocator #(.MAP_WORDS(MAP_WORDS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.word_index(word_index), .word_value(word_value), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .done(done), .found(found), .found_word(found_word),
		.block_number(block_number)
	);

	bba_grant_checker #(.MAP_WORDS(MAP_WORDS)) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.word_index(word_index), .word_value(word_value), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .done(done), .found(found), .found_word(found_word),
		.block_number(block_number), .end_run(end_run), .fails(fails)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) begin
			n_answered <= n_answered + 1;
		end
	end

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic word_t draw_value();
		word_t v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = WORD_FULL;
			4: v = '0;
			5: v = WORD_FULL ^ (WORD_TOP >> $urandom_range(0, 31));
			6: v = WORD_FULL << $urandom_range(1, 31);
			7: v = 32'h1;
			default: v = $urandom();
		endcase
		return v;
	endfunction

	task automatic issue_request(input kind_t k, input logic [IDX_BITS-1:0] idx,
		input word_t val, input int gap);
		start <= 1'b1;
		kind <= k;
		word_index <= idx;
		word_value <= val;
		do @(negedge clk); while (busy);
		@(posedge clk);
		n_issued++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_quiet();
		do @(negedge clk); while (busy || n_answered != n_issued);
	endtask

	task automatic set_search_len(input logic [USE_BITS-1:0] len);
		start <= 1'b0;
		wait_quiet();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		#16000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int                  n_random;
		int                  phase;
		int                  phase_items;
		int                  span;
		int                  hi;
		bit                  calm;
		logic [USE_BITS-1:0] len;
		kind_t               k;
		logic [IDX_BITS-1:0] idx;
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_LOAD;
		word_index = '0;
		word_value = '0;
		cfg_we = 1'b0;
		cfg_wdata = USE_RESET;
		end_run = 1'b0;
		n_random = 0;
		phase = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: first fit inside a word, word skip, last bit, full map, short searches
		issue_request(KIND_ALLOC, '0, '0, 0);
		issue_request(KIND_ALLOC, 9'h1FF, WORD_FULL, 0);
		issue_request(KIND_LOAD, 9'd0, WORD_FULL, 0);
		issue_request(KIND_ALLOC, '0, '0, 0);
		issue_request(KIND_LOAD, 9'd1, 32'hFFFF_FFFE, 0);
		issue_request(KIND_ALLOC, '0, '0, 0);
		issue_request(KIND_LOAD, 9'd511, 32'h7FFF_FFFF, 0);
		issue_request(KIND_LOAD, 9'd2, 32'hAAAA_AAAA, 0);
		issue_request(KIND_ALLOC, '0, '0, 0);
		set_search_len(10'd2);
		issue_request(KIND_ALLOC, '0, '0, 0);
		set_search_len(10'd0);
		issue_request(KIND_ALLOC, '0, '0, 0);
		set_search_len(10'd1);
		issue_request(KIND_ALLOC, '0, '0, 0);
		issue_request(KIND_LOAD, 9'd0, '0, 0);
		issue_request(KIND_ALLOC, '0, '0, 0);
		set_search_len(10'd1023);
		issue_request(KIND_ALLOC, '0, '0, 0);
		issue_request(KIND_LOAD, 9'd511, WORD_FULL, 0);
		issue_request(KIND_ALLOC, '0, '0, 0);

		while (n_random < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: len = 10'd0;
				1: len = 10'd1;
				2: len = 10'd512;
				3: len = 10'd1023;
				4: len = USE_BITS'($urandom_range(513, 1022));
				default: len = USE_BITS'($urandom_range(2, 24));
			endcase
			if (phase == 2) len = 10'd1023;
			set_search_len(len);
			span = (len > MAP_WORDS) ? MAP_WORDS : len;
			hi = (span + 1 > 511) ? 511 : span + 1;
			calm = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				// fill the low words so allocations scan deep
				phase_items = $urandom_range(40, 80);
				for (int w = 0; w < phase_items; w++) begin
					issue_request(KIND_LOAD, IDX_BITS'(w), WORD_FULL, calm ? 0 : next_gap());
				end
				n_random += phase_items;
			end
			phase_items = $urandom_range(15, 45);
			repeat (phase_items) begin
				k = ($urandom_range(0, 99) < 55) ? KIND_ALLOC : KIND_LOAD;
				idx = IDX_BITS'(($urandom_range(0, 3) != 0) ? $urandom_range(0, hi)
					: $urandom_range(0, 511));
				issue_request(k, idx, draw_value(), calm ? 0 : next_gap());
			end
			n_random += phase_items;
			phase++;
		end

		start <= 1'b0;
		wait_quiet();
		repeat (8) @(posedge clk);
		end_run <= 1'b1;
		@(posedge clk);
		@(negedge clk);
		if (fails == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
